// ----- src/drc_pkg.sv -----
// shared types, constants and tables of the dynamic range compressor
package drc_pkg;

  localparam int CHANNELS_DEF    = 8;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_AW-1:0] CFG_TOPOLOGY  = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_RATIO     = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_THRESHOLD = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_KNEE      = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_ATTACK    = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_RELEASE   = 3'd5;

  localparam logic MODE_FF = 1'b0;
  localparam logic MODE_FB = 1'b1;

  localparam logic [12:0]        RATIO_RST     = 13'd1024;
  localparam logic signed [15:0] THRESHOLD_RST = -16'sd5120;
  localparam logic [12:0]        KNEE_RST      = 13'd1536;
  localparam logic [15:0]        ATTACK_RST    = 16'd58982;
  localparam logic [15:0]        RELEASE_RST   = 16'd65208;

  localparam logic [12:0] RATIO_UNITY = 13'd256;

  localparam logic [16:0] DB_PER_LOG2_Q12 = 17'd24660;
  localparam logic [16:0] LOG2_PER_DB_Q16 = 17'd10885;
  localparam logic [16:0] UNITY_Q16       = 17'd65536;

  // rounded q1.16 values of 2^(2^-k), k = 8 down to 1
  localparam logic [16:0] POW2_FRAC [8] = '{
    17'd65714, 17'd65892, 17'd66250, 17'd66971,
    17'd68438, 17'd71468, 17'd77936, 17'd92682
  };

  typedef enum logic [4:0] {
    S_IDLE, S_SLOPE, S_NORM, S_SQ, S_SQ_W, S_NL, S_NL_W, S_TGT, S_HARD_W,
    S_MID1, S_MID2, S_MID3, S_SM1, S_SM2, S_SM3, S_GE, S_GE_W, S_GP, S_GP_W,
    S_GS, S_AP, S_AP_W, S_FBL, S_WB, S_OUT
  } state_t;

endpackage

// ----- src/drc_ram.sv -----
// generic single-port-write ram with registered read
module drc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/drc_mul.sv -----
// shared registered multiplier, 32 x 17 bits unsigned
module drc_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [16:0] b,
  output logic [48:0] p
);

  always_ff @(posedge clk) begin
    p <= 49'(a) * 49'(b);
  end

endmodule

// ----- src/drc_div.sv -----
// restoring divider, one quotient bit per cycle, 16-bit quotient
module drc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [28:0] dividend,
  input  logic [12:0] divisor,
  output logic [15:0] quot,
  output logic        done
);

  logic [12:0] rem;
  logic [15:0] dq;
  logic [4:0]  cnt;
  logic        busy;
  logic [13:0] sh;
  logic        fits;

  assign sh   = {rem, dq[15]};
  assign fits = (sh >= {1'b0, divisor});
  assign quot = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd16;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend top must stay below divisor so the quotient fits 16 bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[28:16];
      dq  <= dividend[15:0];
    end else if (busy) begin
      if (fits) begin
        rem <= 13'(sh - {1'b0, divisor});
      end else begin
        rem <= sh[12:0];
      end
      dq <= {dq[14:0], fits};
    end
  end

endmodule

// ----- src/dynamic_range_compressor_core.sv -----
// top level of the log-domain soft-knee dynamic range compressor
// one request carries a channel number and a q1.(SAMPLE_BITS-1) sample and
// gives back one compressed, saturated sample on the same channel. each
// channel keeps a q8.8 gain reduction in a small ram (valid bits make it read
// as 0 dB after reset, no clearing pass). requests are worked one at a time by
// a sequencer around one registered 32x17 multiplier and one 16-step serial
// divider: the slope division, a one-bit-per-cycle normalize of the level
// magnitude (the magnitude floor sits 17 bits below full scale), eight square
// steps for log2 and eight product steps for the exp table. a request on a
// channel at or above CHANNELS is passed through with no state change. the
// result sits in an output register, so a new request is taken while the
// previous result still waits. config writes land in a register and must only
// happen while the block is idle.
module dynamic_range_compressor_core #(
  parameter int CHANNELS    = drc_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = drc_pkg::SAMPLE_BITS_DEF,
  localparam int TDW = ((3 + SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  // input stream
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [TDW-1:0]            s_tdata,   // channel, sample_in
  // output stream
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [TDW-1:0]            m_tdata,   // channel_out, sample_out
  // config write port
  input  logic                      cfg_we,
  input  logic [drc_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [drc_pkg::CFG_DW-1:0] cfg_wdata
);

  localparam int SB = SAMPLE_BITS;
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NW = SB + 16;          // normalize register
  localparam int ZW = $clog2(SB);       // leading-zero count
  localparam longint FLOOR_RAW = ((64'd1 << (SB - 1)) + 64'd50000) / 64'd100000;
  localparam logic [SB-1:0] MAG_FLOOR = (FLOOR_RAW == 0) ? SB'(1) : SB'(FLOOR_RAW);
  localparam logic [32:0] FS    = 33'd1 << (SB - 1);
  localparam logic [SB-1:0] SMAX = SB'(FS - 33'd1);
  localparam logic [SB-1:0] SMIN = SB'(FS);

  // config registers
  logic                topology_mode;
  logic [12:0]         ratio_q8;
  logic signed [15:0]  threshold_db_q8;
  logic [12:0]         knee_db_q8;
  logic [15:0]         attack_coeff;
  logic [15:0]         release_coeff;

  always_ff @(posedge clk) begin
    if (rst) begin
      topology_mode   <= drc_pkg::MODE_FF;
      ratio_q8        <= drc_pkg::RATIO_RST;
      threshold_db_q8 <= drc_pkg::THRESHOLD_RST;
      knee_db_q8      <= drc_pkg::KNEE_RST;
      attack_coeff    <= drc_pkg::ATTACK_RST;
      release_coeff   <= drc_pkg::RELEASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        drc_pkg::CFG_TOPOLOGY:  topology_mode   <= cfg_wdata[0];
        drc_pkg::CFG_RATIO:     ratio_q8        <= cfg_wdata[12:0];
        drc_pkg::CFG_THRESHOLD: threshold_db_q8 <= cfg_wdata;
        drc_pkg::CFG_KNEE:      knee_db_q8      <= cfg_wdata[12:0];
        drc_pkg::CFG_ATTACK:    attack_coeff    <= cfg_wdata;
        drc_pkg::CFG_RELEASE:   release_coeff   <= cfg_wdata;
        default: ;              // unused indexes are dropped
      endcase
    end
  end

  // sequencer state
  drc_pkg::state_t state, state_next;

  // datapath registers
  logic [2:0]            ch;
  logic signed [SB-1:0]  smp;
  logic [15:0]           slope;
  logic [15:0]           rr;         // current gain reduction, q8.8
  logic [NW-1:0]         x;
  logic [ZW-1:0]         z;
  logic [16:0]           m;
  logic [7:0]            frac;
  logic [2:0]            step;
  logic signed [17:0]    lvl;        // level in db, q8.8
  logic [16:0]           tgt;
  logic [31:0]           acc;
  logic [5:0]            ish;
  logic [7:0]            fb;
  logic [16:0]           gm;
  logic [16:0]           gain;       // linear gain q1.16
  logic signed [SB-1:0]  y;
  logic [CHANNELS-1:0]   vld;

  // output register
  logic [2:0]            ch_out;
  logic [SB-1:0]         y_out;

  // shared units
  logic [31:0] mul_a;
  logic [16:0] mul_b;
  logic [48:0] prod;
  logic        div_start;
  logic [28:0] div_num;
  logic [12:0] div_den;
  logic [15:0] div_q;
  logic        div_done;
  logic        ram_we;
  logic [15:0] ram_rd;

  drc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  drc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .quot     (div_q),
    .done     (div_done)
  );

  logic [CW-1:0] cidx;
  assign cidx = CW'(ch);

  drc_ram #(
    .WIDTH (16),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cidx),
    .wdata (rr),
    .raddr (cidx),
    .rdata (ram_rd)
  );

  // combinational helpers
  logic                 accept;
  logic                 ch_ok;
  logic [SB-1:0]        abs_s;
  logic [SB-1:0]        abs_y;
  logic [ZW+7:0]        nl;
  logic signed [19:0]   l2, t2, kk, x2;
  logic signed [18:0]   dlt;
  logic [15:0]          coef;
  logic [16:0]          omc;

  assign accept = s_tvalid && s_tready;
  assign ch_ok  = (32'(ch) < 32'(CHANNELS));
  assign abs_s  = smp[SB-1] ? SB'(-smp) : SB'(smp);
  assign abs_y  = y[SB-1] ? SB'(-y) : SB'(y);
  assign nl     = {z, 8'b0} - (ZW+8)'(frac);
  assign l2     = {lvl[17], lvl, 1'b0};
  assign t2     = {{3{threshold_db_q8[15]}}, threshold_db_q8, 1'b0};
  assign kk     = {7'b0, knee_db_q8};
  assign x2     = l2 - t2 + kk;
  assign dlt    = {lvl[17], lvl} - {{3{threshold_db_q8[15]}}, threshold_db_q8};
  // attack when the reduction grows
  assign coef   = (tgt > {1'b0, rr}) ? attack_coeff : release_coeff;
  assign omc    = drc_pkg::UNITY_Q16 - {1'b0, coef};

  function automatic logic [SB-1:0] floor_mag(input logic [SB-1:0] v);
    return (v < MAG_FLOOR) ? MAG_FLOOR : v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= drc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and unit controls
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_num    = {13'(ratio_q8 - drc_pkg::RATIO_UNITY), 16'b0};
    div_den    = ratio_q8;
    ram_we     = 1'b0;
    s_tready   = 1'b0;
    unique case (state)
      drc_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          div_start  = 1'b1;
          state_next = drc_pkg::S_SLOPE;
        end
      end
      drc_pkg::S_SLOPE: begin
        if (div_done) begin
          if (!ch_ok) begin
            state_next = drc_pkg::S_OUT;
          end else if (topology_mode == drc_pkg::MODE_FF) begin
            state_next = drc_pkg::S_NORM;
          end else begin
            state_next = drc_pkg::S_GE;
          end
        end
      end
      drc_pkg::S_NORM: begin
        if (x[NW-1]) begin
          state_next = drc_pkg::S_SQ;
        end
      end
      drc_pkg::S_SQ: begin
        mul_a      = 32'(m);
        mul_b      = m;
        state_next = drc_pkg::S_SQ_W;
      end
      drc_pkg::S_SQ_W: begin
        state_next = (step == 3'd7) ? drc_pkg::S_NL : drc_pkg::S_SQ;
      end
      drc_pkg::S_NL: begin
        mul_a      = 32'(nl);
        mul_b      = drc_pkg::DB_PER_LOG2_Q12;
        state_next = drc_pkg::S_NL_W;
      end
      drc_pkg::S_NL_W: begin
        state_next = drc_pkg::S_TGT;
      end
      drc_pkg::S_TGT: begin
        priority if (topology_mode == drc_pkg::MODE_FF && l2 > t2 + kk) begin
          mul_a      = 32'(dlt[16:0]);
          mul_b      = {1'b0, slope};
          state_next = drc_pkg::S_HARD_W;
        end else if (topology_mode == drc_pkg::MODE_FF && l2 > t2 - kk) begin
          mul_a      = 32'(x2[13:0]);
          mul_b      = 17'(x2[13:0]);
          state_next = drc_pkg::S_MID1;
        end else if (topology_mode == drc_pkg::MODE_FB && dlt > 19'sd0) begin
          mul_a      = 32'(dlt[16:0]);
          mul_b      = {1'b0, slope};
          state_next = drc_pkg::S_HARD_W;
        end else begin
          state_next = drc_pkg::S_SM1;
        end
      end
      drc_pkg::S_HARD_W: begin
        state_next = drc_pkg::S_SM1;
      end
      drc_pkg::S_MID1: begin
        mul_a      = prod[31:0];
        mul_b      = {1'b0, slope};
        state_next = drc_pkg::S_MID2;
      end
      drc_pkg::S_MID2: begin
        // divide by 8*knee*65536 as a shift then a divide by knee
        div_start  = 1'b1;
        div_num    = prod[47:19];
        div_den    = knee_db_q8;
        state_next = drc_pkg::S_MID3;
      end
      drc_pkg::S_MID3: begin
        div_den = knee_db_q8;
        if (div_done) begin
          state_next = drc_pkg::S_SM1;
        end
      end
      drc_pkg::S_SM1: begin
        mul_a      = 32'(rr);
        mul_b      = {1'b0, coef};
        state_next = drc_pkg::S_SM2;
      end
      drc_pkg::S_SM2: begin
        mul_a      = 32'(tgt);
        mul_b      = omc;
        state_next = drc_pkg::S_SM3;
      end
      drc_pkg::S_SM3: begin
        state_next = (topology_mode == drc_pkg::MODE_FF) ? drc_pkg::S_GE : drc_pkg::S_WB;
      end
      drc_pkg::S_GE: begin
        mul_a      = 32'(rr);
        mul_b      = drc_pkg::LOG2_PER_DB_Q16;
        state_next = drc_pkg::S_GE_W;
      end
      drc_pkg::S_GE_W: begin
        state_next = drc_pkg::S_GP;
      end
      drc_pkg::S_GP: begin
        mul_a      = 32'(gm);
        mul_b      = drc_pkg::POW2_FRAC[step];
        state_next = drc_pkg::S_GP_W;
      end
      drc_pkg::S_GP_W: begin
        state_next = (step == 3'd7) ? drc_pkg::S_GS : drc_pkg::S_GP;
      end
      drc_pkg::S_GS: begin
        state_next = drc_pkg::S_AP;
      end
      drc_pkg::S_AP: begin
        mul_a      = 32'(abs_s);
        mul_b      = gain;
        state_next = drc_pkg::S_AP_W;
      end
      drc_pkg::S_AP_W: begin
        state_next = (topology_mode == drc_pkg::MODE_FF) ? drc_pkg::S_WB : drc_pkg::S_FBL;
      end
      drc_pkg::S_FBL: begin
        state_next = drc_pkg::S_NORM;
      end
      drc_pkg::S_WB: begin
        ram_we     = 1'b1;
        state_next = drc_pkg::S_OUT;
      end
      drc_pkg::S_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = drc_pkg::S_IDLE;
        end
      end
      default: state_next = drc_pkg::S_IDLE;
    endcase
  end

  // datapath
  logic [17:0] sq_t;
  logic [15:0] lv_mag;
  logic [34:0] sm_sum;
  logic [13:0] e_v;
  logic [5:0]  i_v;
  logic [32:0] mg;

  assign sq_t   = 18'((prod[33:0] + 34'd32768) >> 16);
  assign lv_mag = 16'((prod[27:0] + 28'd2048) >> 12);
  assign sm_sum = 35'(acc) + 35'(prod[33:0]) + 35'd32768;
  assign e_v    = 14'((prod[29:0] + 30'd32768) >> 16);
  assign i_v    = 6'((15'(e_v) + 15'd255) >> 8);
  assign mg     = 33'((prod + 49'd32768) >> 16);

  always_ff @(posedge clk) begin
    unique case (state)
      drc_pkg::S_IDLE: begin
        if (accept) begin
          ch  <= s_tdata[2:0];
          smp <= s_tdata[SB+2:3];
        end
      end
      drc_pkg::S_SLOPE: begin
        if (div_done) begin
          slope <= (ratio_q8 > drc_pkg::RATIO_UNITY) ? div_q : 16'd0;
          rr    <= vld[cidx] ? ram_rd : 16'd0;
          y     <= smp;
          x     <= {floor_mag(abs_s), 16'b0};
          z     <= '0;
          gm    <= drc_pkg::UNITY_Q16;
          step  <= '0;
        end
      end
      drc_pkg::S_NORM: begin
        if (x[NW-1]) begin
          m    <= x[NW-1 -: 17];
          frac <= '0;
          step <= '0;
        end else begin
          x <= {x[NW-2:0], 1'b0};
          z <= z + ZW'(1);
        end
      end
      drc_pkg::S_SQ_W: begin
        step <= step + 3'd1;
        if (sq_t[17]) begin
          frac <= {frac[6:0], 1'b1};
          m    <= sq_t[17:1];
        end else begin
          frac <= {frac[6:0], 1'b0};
          m    <= sq_t[16:0];
        end
      end
      drc_pkg::S_NL_W: begin
        lvl <= 18'sd0 - $signed({2'b0, lv_mag});
        tgt <= '0;
      end
      drc_pkg::S_HARD_W: tgt <= prod[32:16];
      drc_pkg::S_MID3: begin
        if (div_done) begin
          tgt <= {1'b0, div_q};
        end
      end
      drc_pkg::S_SM2: acc <= prod[31:0];
      drc_pkg::S_SM3: begin
        rr   <= sm_sum[31:16];
        gm   <= drc_pkg::UNITY_Q16;
        step <= '0;
      end
      drc_pkg::S_GE_W: begin
        ish <= i_v;
        fb  <= 8'({i_v, 8'b0} - e_v);
      end
      drc_pkg::S_GP_W: begin
        step <= step + 3'd1;
        if (fb[step]) begin
          gm <= 17'((prod[33:0] + 34'd32768) >> 16);
        end
      end
      // shifts of more than 16 leave nothing, which covers the gain-zero case
      drc_pkg::S_GS: gain <= gm >> ish;
      drc_pkg::S_AP_W: begin
        if (!smp[SB-1]) begin
          y <= (mg > FS - 33'd1) ? SMAX : SB'(mg);
        end else begin
          y <= (mg > FS) ? SMIN : SB'(33'd0 - mg);
        end
      end
      drc_pkg::S_FBL: begin
        x <= {floor_mag(abs_y), 16'b0};
        z <= '0;
      end
      default: ;
    endcase
  end

  // valid bits stand in for a cleared envelope ram
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ram_we) begin
      vld[cidx] <= 1'b1;
    end
  end

  // output register, freed by the downstream request
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == drc_pkg::S_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == drc_pkg::S_OUT && (!m_tvalid || m_tready)) begin
      ch_out <= ch;
      y_out  <= y;
    end
  end

  assign m_tdata = TDW'({y_out, ch_out});

`ifndef SYNTHESIS
  // one request at a time: no back-to-back accept
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("request accepted while another is in flight");

  // envelope ram only written for channels that exist
  a_wb_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ch_ok)
    else $error("envelope write for out-of-range channel");

  // divider results only arrive where the sequencer waits for them
  a_div_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == drc_pkg::S_SLOPE || state == drc_pkg::S_MID3))
    else $error("divider finished outside a wait state");

  // attenuation only: gain never above unity when applied
  a_gain_unity: assert property (@(posedge clk) disable iff (rst)
    (state == drc_pkg::S_AP) |-> (gain <= drc_pkg::UNITY_Q16))
    else $error("gain above unity");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
// self-checking testbench of the dynamic range compressor core
`timescale 1ns / 1ps

module tb_top;

  localparam int CH = 8;
  localparam int SB = 24;
  localparam int TDW = ((3 + SB + 7) / 8) * 8;
  localparam longint FS = 64'd1 << (SB - 1);
  localparam longint MAG_FLOOR = (FS + 50000) / 100000;

  typedef struct {
    logic [2:0]  ch;
    logic [23:0] smp;
  } drc_item_t;

  // predictor of the compressor with its own copy of config and envelopes
  class drc_scoreboard;
    logic        mode;
    logic [12:0] ratio;
    int          thr;
    int          knee;
    longint      att;
    longint      rel;
    longint      env [CH];
    drc_item_t   pending [$];
    int          errors;

    function new();
      mode = drc_pkg::MODE_FF;
      ratio = drc_pkg::RATIO_RST;
      thr = int'(drc_pkg::THRESHOLD_RST);
      knee = int'(drc_pkg::KNEE_RST);
      att = longint'(drc_pkg::ATTACK_RST);
      rel = longint'(drc_pkg::RELEASE_RST);
      errors = 0;
      foreach (env[i]) env[i] = 0;
    endfunction

    function void write_reg(logic [2:0] a, logic [15:0] d);
      case (a)
        drc_pkg::CFG_TOPOLOGY:  mode = d[0];
        drc_pkg::CFG_RATIO:     ratio = d[12:0];
        drc_pkg::CFG_THRESHOLD: thr = int'($signed(d));
        drc_pkg::CFG_KNEE:      knee = int'(d[12:0]);
        drc_pkg::CFG_ATTACK:    att = longint'(d);
        drc_pkg::CFG_RELEASE:   rel = longint'(d);
        default: ;
      endcase
    endfunction

    function int level_db(longint mag);
      longint m;
      int p, frac, nl;
      p = 0; frac = 0;
      if (mag < MAG_FLOOR) mag = MAG_FLOOR;
      if (mag > FS) mag = FS;
      for (int k = 0; k < 63; k++) if (mag[k]) p = k;
      m = (p <= 16) ? (mag << (16 - p)) : (mag >> (p - 16));
      for (int k = 0; k < 8; k++) begin
        m = (m * m + 32768) >> 16;
        frac = frac << 1;
        if (m >= 131072) begin
          frac = frac | 1;
          m = m >> 1;
        end
      end
      nl = (SB - 1 - p) * 256 - frac;
      return -int'((longint'(nl) * longint'(drc_pkg::DB_PER_LOG2_Q12) + 2048) >> 12);
    endfunction

    function longint gain_q16(longint r);
      longint e, i, f, m;
      e = (r * longint'(drc_pkg::LOG2_PER_DB_Q16) + 32768) >> 16;
      i = (e + 255) >> 8;
      f = i * 256 - e;
      m = 65536;
      if (i > 40) return 0;
      for (int k = 0; k < 8; k++) begin
        if (f[k]) m = (m * longint'(drc_pkg::POW2_FRAC[k]) + 32768) >> 16;
      end
      return m >> i;
    endfunction

    function longint apply_gain(longint s, longint g);
      longint mag, v;
      mag = (s < 0) ? -s : s;
      mag = (mag * g + 32768) >> 16;
      v = (s < 0) ? -mag : mag;
      if (v > FS - 1) v = FS - 1;
      if (v < -FS) v = -FS;
      return v;
    endfunction

    function longint hard_tgt(int lvl, longint slope);
      if (lvl > thr) return (longint'(lvl - thr) * slope) >> 16;
      return 0;
    endfunction

    function longint smooth(longint r, longint t);
      longint a;
      a = (t > r) ? att : rel;
      return (a * r + (65536 - a) * t + 32768) >> 16;
    endfunction

    function drc_item_t compress(drc_item_t it);
      drc_item_t o;
      longint s, y, slope, r, t, x2, rl;
      int lvl;
      s = longint'($signed(it.smp));
      y = s;
      slope = 0;
      rl = longint'(ratio);
      if (ratio > drc_pkg::RATIO_UNITY) slope = ((rl - 256) << 16) / rl;
      if (int'(it.ch) < CH) begin
        r = env[it.ch];
        if (mode == drc_pkg::MODE_FF) begin
          lvl = level_db(s < 0 ? -s : s);
          if (2 * lvl > 2 * thr + knee) t = hard_tgt(lvl, slope);
          else if (2 * lvl > 2 * thr - knee) begin
            x2 = longint'(2 * lvl - 2 * thr + knee);
            t = (x2 * x2 * slope) / (longint'(knee) * 8 * 65536);
          end else t = 0;
          r = smooth(r, t);
          y = apply_gain(s, gain_q16(r));
        end else begin
          y = apply_gain(s, gain_q16(r));
          lvl = level_db(y < 0 ? -y : y);
          r = smooth(r, hard_tgt(lvl, slope));
        end
        env[it.ch] = (r > 65535) ? 65535 : r;
      end
      o.ch = it.ch;
      o.smp = y[23:0];
      return o;
    endfunction

    function void note_request(drc_item_t it);
      pending.push_back(compress(it));
    endfunction

    function void check_result(drc_item_t got);
      drc_item_t exp_it;
      if (pending.size() == 0) begin
        $display("%0t unexpected result: expected none, actual ch %0d sample %h",
                 $time, got.ch, got.smp);
        errors++;
        return;
      end
      exp_it = pending.pop_front();
      if (got.ch !== exp_it.ch) begin
        $display("%0t channel_out mismatch: expected %0d actual %0d",
                 $time, exp_it.ch, got.ch);
        errors++;
      end
      if (got.smp !== exp_it.smp) begin
        $display("%0t sample_out mismatch: expected %h actual %h",
                 $time, exp_it.smp, got.smp);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready, cfg_we;
  logic [TDW-1:0] s_tdata, m_tdata;
  logic [drc_pkg::CFG_AW-1:0] cfg_addr;
  logic [drc_pkg::CFG_DW-1:0] cfg_wdata;

  drc_scoreboard sb = new();
  bit rx_idle_on = 1;   // random receiver stalls allowed
  bit rx_hold = 0;      // long receiver hold-off
  bit tx_idle_on = 1;

  dynamic_range_compressor_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: random bursts of stall, check each accepted result
  initial begin
    int gap;
    drc_item_t got;
    m_tready = 0;
    gap = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got.ch = m_tdata[2:0];
        got.smp = m_tdata[26:3];
        sb.check_result(got);
      end
      if (rx_hold) m_tready <= 0;
      else if (gap > 0) begin
        gap--;
        m_tready <= 0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        gap = int'($urandom_range(1, 4)) - 1;
        m_tready <= 0;
      end else m_tready <= 1;
    end
  end

  // one request; valid stays high across back-to-back requests
  task automatic send(drc_item_t it);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {5'b0, it.smp, it.ch};
    do @(posedge clk); while (!s_tready);
    sb.note_request(it);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);   // settle before the next config change
  endtask

  // one write, then the write enable is driven low again
  task automatic write_reg(logic [2:0] a, logic [15:0] d);
    cfg_we <= 1;
    cfg_addr <= a;
    cfg_wdata <= d;
    @(posedge clk);
    sb.write_reg(a, d);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 24'($urandom_range(0, 300) - 150);
      1: return 24'({$urandom} >> $urandom_range(0, 23));
      2: return 24'(-({$urandom} >> $urandom_range(1, 23)));
      3: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic random_burst(int n);
    drc_item_t it;
    for (int i = 0; i < n; i++) begin
      it.ch = ($urandom_range(0, 15) == 0) ? 3'd7 : 3'($urandom_range(0, 7));
      it.smp = rand_sample();
      send(it);
    end
  endtask

  initial begin
    drc_item_t it;
    logic [23:0] dir [] = '{24'h7fffff, 24'h800000, 24'h000000, 24'h000001,
                            24'hffffff, 24'h000054, 24'h000053, 24'h400000,
                            24'hc00000, 24'h555555, 24'haaaaaa, 24'h0000ff};
    rst = 1; s_tvalid = 0; s_tdata = 0; cfg_we = 0; cfg_addr = 0; cfg_wdata = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes with reset settings on every channel
    foreach (dir[i]) begin
      it.ch = 3'(i % 8); it.smp = dir[i];
      send(it);
    end
    drain();
    // zero knee, ratio below one, threshold above zero, fast coefficients
    write_reg(drc_pkg::CFG_KNEE, 16'd0);
    write_reg(drc_pkg::CFG_RATIO, 16'd0);
    write_reg(drc_pkg::CFG_ATTACK, 16'd0);
    write_reg(drc_pkg::CFG_RELEASE, 16'd0);
    for (int i = 0; i < 4; i++) begin
      it.ch = 3'(i); it.smp = dir[i];
      send(it);
    end
    drain();
    write_reg(drc_pkg::CFG_RATIO, 16'd5120);
    write_reg(drc_pkg::CFG_THRESHOLD, 16'd256);
    for (int i = 0; i < 3; i++) begin
      it.ch = 3'(i); it.smp = 24'h7fffff;
      send(it);
    end
    drain();
    // very large reduction: lowest threshold, max ratio, instant attack
    write_reg(drc_pkg::CFG_THRESHOLD, 16'h9c00);
    for (int i = 0; i < 4; i++) begin
      it.ch = 3'd3; it.smp = 24'h7fffff;
      send(it);
    end
    drain();

    // random phases through several settings
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(drc_pkg::CFG_TOPOLOGY, 16'(ph % 2));
      write_reg(drc_pkg::CFG_RATIO, ph == 2 ? 16'd256 : ph == 3 ? 16'd5120
                                    : 16'($urandom_range(100, 5120)));
      write_reg(drc_pkg::CFG_THRESHOLD, ph == 4 ? 16'h9c00 : ph == 5 ? 16'd0
                                        : 16'(-int'($urandom_range(0, 12000))));
      write_reg(drc_pkg::CFG_KNEE, ph == 6 ? 16'd6144 : ph == 7 ? 16'd0
                                   : 16'($urandom_range(0, 6144)));
      write_reg(drc_pkg::CFG_ATTACK, ph == 8 ? 16'hffff
                                     : 16'($urandom_range(0, 65535)));
      write_reg(drc_pkg::CFG_RELEASE, ph == 9 ? 16'hffff
                                      : 16'($urandom_range(40000, 65535)));
      if (ph == 3) begin
        // receiver holds off while the sender keeps offering requests
        fork
          begin
            rx_hold = 1;
            repeat (600) @(posedge clk);
            rx_hold = 0;
          end
          random_burst(110);
        join
      end else begin
        if (ph == 9) begin
          rx_idle_on = 0;
          tx_idle_on = 0;
        end
        random_burst(110);
      end
      drain();   // sender pauses until every result is in
    end

    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule
